>>> rtl/ssis_pkg.sv
// ----------------------------------------------------------------------------
// ssis_pkg
// Shared constants and types for the sorted set insert/search block.
// ----------------------------------------------------------------------------
package ssis_pkg;

    localparam int CAPACITY  = 16;
    localparam int VALUE_W   = 32;
    localparam int COUNT_W   = $clog2(CAPACITY + 1);
    localparam int STATUS_W  = 3;
    localparam int OUT_CNT_W = 5;

    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_SEARCH = 1'b1
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED  = 3'd0,
        ST_DUPLICATE = 3'd1,
        ST_FULL      = 3'd2,
        ST_FOUND     = 3'd3,
        ST_NOT_FOUND = 3'd4
    } status_t;

    // per-cycle control broadcast to every cell
    typedef struct packed {
        logic compare;
        logic commit;
    } cell_ctrl_t;

endpackage

>>> rtl/sorted_set_insert_search.sv
// ----------------------------------------------------------------------------
// sorted_set_insert_search
// Sorted set of distinct signed words with insert and membership search.
// ----------------------------------------------------------------------------
// Usage:
//   s_command/s_value form one input word (insert or search), taken when
//   s_valid and s_ready are both high. Every word yields exactly one result
//   word on m_status/m_entry_count, held until m_valid and m_ready meet.
//   Values live in a chain of CAPACITY cells, kept ascending from cell 0.
//   A taken word is registered, then all cells compare in parallel in S_CMP,
//   then in S_DONE the duplicate/full decision is made, the chain shifts on
//   insert and the result is registered (S_DONE waits for a free output).
//   No new word is taken until the last one has left S_DONE; s_ready is
//   high only while the sequencer is idle.
//   A new word is taken while an earlier result still waits on m_ready; the
//   commit of that new word waits until the output register is free.
//   Reset empties the set (count goes to zero); entry contents are not
//   cleared, only slots below the count are ever looked at.
// ----------------------------------------------------------------------------
module sorted_set_insert_search (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_command,
    input  logic signed [ssis_pkg::VALUE_W-1:0] s_value,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [ssis_pkg::STATUS_W-1:0]       m_status,
    output logic [ssis_pkg::OUT_CNT_W-1:0]      m_entry_count
);
    import ssis_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_DONE
    } state_t;

    state_t                    state_reg;
    logic                      cmd_reg;
    logic signed [VALUE_W-1:0] value_reg;
    logic [COUNT_W-1:0]        count_reg;
    logic                      m_valid_reg;
    logic [STATUS_W-1:0]       m_status_reg;
    logic [OUT_CNT_W-1:0]      m_count_reg;

    logic signed [VALUE_W-1:0] entry_vec [CAPACITY];
    logic [CAPACITY-1:0]       gt_vec;
    logic [CAPACITY-1:0]       match_vec;
    logic [CAPACITY-1:0]       occ_vec;

    cell_ctrl_t         ctrl;
    logic               any_match;
    logic               is_full;
    logic               out_free;
    logic               finish;
    logic               do_insert;
    status_t            status_next;
    logic [COUNT_W-1:0] count_next;

    assign any_match = |match_vec;
    assign is_full   = (count_reg == COUNT_W'(CAPACITY));
    assign out_free  = !m_valid_reg || m_ready;
    assign finish    = (state_reg == S_DONE) && out_free;
    assign do_insert = (cmd_reg == CMD_INSERT) && !any_match && !is_full;

    assign ctrl.compare = (state_reg == S_CMP);
    assign ctrl.commit  = finish && do_insert;

    always_comb begin
        if (cmd_reg == CMD_SEARCH) begin
            status_next = any_match ? ST_FOUND : ST_NOT_FOUND;
        end else if (any_match) begin
            status_next = ST_DUPLICATE;
        end else if (is_full) begin
            status_next = ST_FULL;
        end else begin
            status_next = ST_INSERTED;
        end
        count_next = do_insert ? count_reg + COUNT_W'(1) : count_reg;
    end

    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++) begin : g_cell
            logic signed [VALUE_W-1:0] left_entry;
            logic                      left_gt;

            assign occ_vec[i] = (COUNT_W'(i) < count_reg);

            if (i == 0) begin : g_head
                assign left_entry = '0;
                assign left_gt    = 1'b0;
            end else begin : g_link
                assign left_entry = entry_vec[i-1];
                assign left_gt    = gt_vec[i-1];
            end

            ssis_cell u_cell (
                .aclk       (aclk),
                .ctrl       (ctrl),
                .value      (value_reg),
                .occupied   (occ_vec[i]),
                .left_entry (left_entry),
                .left_gt    (left_gt),
                .entry      (entry_vec[i]),
                .gt         (gt_vec[i]),
                .match      (match_vec[i])
            );
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        cmd_reg   <= s_command;
                        value_reg <= s_value;
                        state_reg <= S_CMP;
                    end
                end
                S_CMP: begin
                    state_reg <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        m_valid_reg  <= 1'b1;
                        m_status_reg <= status_next;
                        m_count_reg  <= OUT_CNT_W'(count_next);
                        count_reg    <= count_next;
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_ready       = (state_reg == S_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_entry_count = m_count_reg;

endmodule

>>> rtl/ssis_cell.sv
// ----------------------------------------------------------------------------
// ssis_cell
// One slot of the sorted chain: compares the broadcast word against its
// entry and, on commit, either keeps its entry, takes the new value or takes
// its left neighbor's entry.
// ----------------------------------------------------------------------------
module ssis_cell (
    input  logic                               aclk,
    input  ssis_pkg::cell_ctrl_t               ctrl,
    input  logic signed [ssis_pkg::VALUE_W-1:0] value,
    input  logic                               occupied,
    input  logic signed [ssis_pkg::VALUE_W-1:0] left_entry,
    input  logic                               left_gt,
    output logic signed [ssis_pkg::VALUE_W-1:0] entry,
    output logic                               gt,
    output logic                               match
);
    import ssis_pkg::*;

    logic signed [VALUE_W-1:0] entry_reg;
    logic                      gt_reg;
    logic                      match_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.compare) begin
            gt_reg    <= occupied && (entry_reg > value);
            match_reg <= occupied && (entry_reg == value);
        end
        if (ctrl.commit) begin
            // larger entries move up one slot, first free or larger slot takes the word
            if (left_gt) begin
                entry_reg <= left_entry;
            end else if (gt_reg || !occupied) begin
                entry_reg <= value;
            end
        end
    end

    assign entry = entry_reg;
    assign gt    = gt_reg;
    assign match = match_reg;

endmodule

>>> dv/sorted_set_insert_search_check.sv
// ----------------------------------------------------------------------------
// sorted_set_insert_search_check
// Watches both channels of the sorted set, keeps its own copy of the held
// values, predicts status and entry count for every accepted input word and
// compares each result word against the oldest prediction.
// ----------------------------------------------------------------------------
module sorted_set_insert_search_check (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    input  logic                                s_ready,
    input  logic                                s_command,
    input  logic signed [ssis_pkg::VALUE_W-1:0] s_value,
    input  logic                                m_valid,
    input  logic                                m_ready,
    input  logic [ssis_pkg::STATUS_W-1:0]       m_status,
    input  logic [ssis_pkg::OUT_CNT_W-1:0]      m_entry_count,
    output int                                  failures,
    output int                                  pending_words,
    output int                                  results_checked
);
    import ssis_pkg::*;

    typedef struct packed {
        status_t                status;
        logic [OUT_CNT_W-1:0]   entry_count;
    } set_outcome_t;

    logic signed [VALUE_W-1:0] members [CAPACITY];
    int           member_count = 0;
    set_outcome_t outcome_queue [$];
    int           n_fail = 0;
    int           n_checked = 0;

    // updates the held set for one word and returns its status
    function automatic status_t apply_word(cmd_t cmd, logic signed [VALUE_W-1:0] v);
        bit present;
        int pos;
        present = 1'b0;
        for (int i = 0; i < member_count; i++) begin
            if (members[i] == v) present = 1'b1;
        end
        if (cmd == CMD_SEARCH) return present ? ST_FOUND : ST_NOT_FOUND;
        // duplicate check wins over the full check
        if (present) return ST_DUPLICATE;
        if (member_count >= CAPACITY) return ST_FULL;
        pos = 0;
        while (pos < member_count && members[pos] < v) pos++;
        for (int k = member_count; k > pos; k--) members[k] = members[k-1];
        members[pos] = v;
        member_count++;
        return ST_INSERTED;
    endfunction

    task automatic report_mismatch(string msg);
        $display("%0t: mismatch: %s", $time, msg);
        n_fail++;
    endtask

    always @(posedge aclk) begin
        set_outcome_t want;
        status_t      st;
        if (!aresetn) begin
            member_count = 0;
            outcome_queue.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (outcome_queue.size() == 0) begin
                    report_mismatch($sformatf("result word with none pending (status %0d, count %0d)",
                                              m_status, m_entry_count));
                end else begin
                    want = outcome_queue.pop_front();
                    n_checked++;
                    if (m_status !== want.status)
                        report_mismatch($sformatf("status %0d, expected %0d (%s)",
                                                  m_status, want.status, want.status.name()));
                    if (m_entry_count !== want.entry_count)
                        report_mismatch($sformatf("entry_count %0d, expected %0d",
                                                  m_entry_count, want.entry_count));
                end
            end
            if (s_valid && s_ready) begin
                st = apply_word(cmd_t'(s_command), s_value);
                want.status      = st;
                want.entry_count = member_count[OUT_CNT_W-1:0];
                outcome_queue.push_back(want);
            end
        end
        failures        <= n_fail;
        pending_words   <= outcome_queue.size();
        results_checked <= n_checked;
    end

endmodule

>>> dv/sorted_set_insert_search_tb.sv
// ----------------------------------------------------------------------------
// sorted_set_insert_search_tb
// Drives insert and search words into the sorted set: a directed opening with
// extreme values, duplicates and empty-table search, then random words biased
// toward inserted values so that duplicates, hits, misses and a full table all
// occur. Sender gaps and receiver stalls change over three idle mixes.
// ----------------------------------------------------------------------------
module sorted_set_insert_search_tb;
    import ssis_pkg::*;

    localparam int RANDOM_WORDS = 1830;
    localparam int STALL_LIMIT  = 2000;

    logic                       aclk = 1'b0;
    logic                       aresetn = 1'b0;
    logic                       s_valid = 1'b0;
    logic                       s_ready;
    logic                       s_command = CMD_INSERT;
    logic signed [VALUE_W-1:0]  s_value = '0;
    logic                       m_valid;
    logic                       m_ready = 1'b0;
    logic [STATUS_W-1:0]        m_status;
    logic [OUT_CNT_W-1:0]       m_entry_count;

    int failures;
    int pending_words;
    int results_checked;
    int send_gap_pct = 17;
    int ready_stall_pct = 77;
    int idle_cycles = 0;
    int n_insert = 0;
    int n_search = 0;

    // every value ever sent with an insert, held or not
    logic signed [VALUE_W-1:0] inserted_values [$];

    always #6 aclk = ~aclk;

    sorted_set_insert_search DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_command     (s_command),
        .s_value       (s_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_entry_count (m_entry_count)
    );

    sorted_set_insert_search_check check_u (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_command       (s_command),
        .s_value         (s_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_entry_count   (m_entry_count),
        .failures        (failures),
        .pending_words   (pending_words),
        .results_checked (results_checked)
    );

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= ready_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= STALL_LIMIT) begin
                $display("no word moved for %0d cycles", STALL_LIMIT);
                $display("sorted_set_insert_search regression: fail");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    task automatic send_word(cmd_t cmd, logic signed [VALUE_W-1:0] v);
        while ($urandom_range(99) < send_gap_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_command <= cmd;
        s_value   <= v;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (cmd == CMD_INSERT) begin
            n_insert++;
            inserted_values.push_back(v);
        end else begin
            n_search++;
        end
    endtask

    initial begin
        logic signed [VALUE_W-1:0] base;
        int pick;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed opening
        send_word(CMD_SEARCH, 32'sd0);               // empty table
        send_word(CMD_INSERT, 32'sd0);
        send_word(CMD_INSERT, 32'sh8000_0000);
        send_word(CMD_INSERT, 32'sh7fff_ffff);
        send_word(CMD_INSERT, -32'sd1);
        send_word(CMD_INSERT, 32'sd1);
        send_word(CMD_INSERT, 32'sd0);               // duplicate
        send_word(CMD_INSERT, 32'sh8000_0000);       // duplicate at the low end
        send_word(CMD_SEARCH, 32'sh8000_0000);
        send_word(CMD_SEARCH, 32'sh7fff_ffff);
        send_word(CMD_SEARCH, -32'sd1);
        send_word(CMD_SEARCH, 32'sd2);
        send_word(CMD_SEARCH, 32'sh7fff_fffe);
        send_word(CMD_SEARCH, 32'sh8000_0001);
        send_word(CMD_INSERT, 32'sh5555_5555);
        send_word(CMD_INSERT, 32'shaaaa_aaaa);

        // random part: new values trickle in so the table fills midway
        for (int i = 0; i < RANDOM_WORDS; i++) begin
            if (i == RANDOM_WORDS / 3) begin
                send_gap_pct = 77;
                ready_stall_pct <= 17;
            end else if (i == 2 * RANDOM_WORDS / 3) begin
                send_gap_pct = 0;
                ready_stall_pct <= 0;
            end
            pick = $urandom_range(99);
            if (inserted_values.size() == 0 || i % 100 == 50 || $urandom_range(199) == 0) begin
                send_word(CMD_INSERT, $urandom);
            end else begin
                base = inserted_values[$urandom_range(inserted_values.size() - 1)];
                if (pick < 30)
                    send_word(CMD_INSERT, base);
                else if (pick < 65)
                    send_word(CMD_SEARCH, base);
                else if (pick < 85)
                    send_word(CMD_SEARCH, pick[0] ? base + 32'sd1 : base - 32'sd1);
                else
                    send_word(CMD_SEARCH, $urandom);
            end
        end
        s_valid <= 1'b0;

        @(posedge aclk);
        while (pending_words != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        $display("covered %0d words (%0d inserts, %0d searches), %0d results checked",
                 n_insert + n_search, n_insert, n_search, results_checked);
        $display("idle mixes: sparse sender gaps with heavy stalls, the reverse, then none");
        if (failures == 0 && pending_words == 0) begin
            $display("sorted_set_insert_search regression: pass");
        end else begin
            $display("sorted_set_insert_search regression: fail");
        end
        $finish;
    end

endmodule
